// ===== design/uvd_pkg.sv =====
// ----------------------------------------------------------------------------
// uvd_pkg
// shared types and constants for the unique value deque
// ----------------------------------------------------------------------------
package uvd_pkg;
  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_LIST_FWD   = 3'd6,
    OP_LIST_BWD   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture input beat, clear offset
    logic       rd;        // read entry at offset (offset may be reversed)
    logic       rev;       // read from the back
    logic       step;      // offset + 1
    logic       shift;     // write entry[off] <= entry[off+1]
    logic       wr_front;  // push front
    logic       wr_back;   // push back
    logic       pop_front;
    logic       pop_back;
    logic       dec;       // count - 1 (remove)
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       at_end;    // offset == count
    logic       at_last;   // offset + 1 == count
    logic       match;     // registered read data equals value
  } sts_t;
endpackage

// ===== design/uvd_if.sv =====
// ----------------------------------------------------------------------------
// uvd_in_if / uvd_out_if
// valid/ready channels for operation beats and result beats
// ----------------------------------------------------------------------------
interface uvd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [31:0] value;
  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface uvd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic signed [31:0] item;
  logic        last;
  modport source (output valid, status, found, item, last, input ready);
  modport sink (input valid, status, found, item, last, output ready);
endinterface

// ===== design/unique_value_deque_core.sv =====
// ----------------------------------------------------------------------------
// unique_value_deque_core
// ordered list of unique signed values with push, pop, remove, search, list
// ----------------------------------------------------------------------------
// push, search and remove scan the list and end early on a match; pop reads the head or tail entry
// an empty list gives an error beat straight from idle; listing gives one beat per element, held until taken
// one operation at a time: a new operation is taken only after the last result beat is taken
// the entry store is walked one entry at a time through one read port, a read state then a compare state
// reset: synchronous rst empties the list; entries hold no reset value
module unique_value_deque_core
  import uvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  uvd_in_if.sink    in_ch,
  uvd_out_if.source out_ch
);
  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] rd_data, value;

  uvd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cmd(cmd), .sts(sts), .rd_data(rd_data), .value(value)
  );

  uvd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_value(in_ch.value),
    .sts(sts), .rd_data(rd_data), .value(value)
  );
endmodule

// ===== design/uvd_datapath.sv =====
// ----------------------------------------------------------------------------
// uvd_datapath
// entry memory, head pointer, count and walk offset
// ----------------------------------------------------------------------------
module uvd_datapath
  import uvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic signed [31:0] in_value,
  output sts_t               sts,
  output logic signed [31:0] rd_data,
  output logic signed [31:0] value
);
  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] off;
  logic [AW-1:0] rd_addr, sh_dst, sh_src, back_addr, front_addr;
  logic [CW-1:0] rd_off;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, o};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign rd_off     = cmd.rev ? count - off - CW'(1) : off;
  assign rd_addr    = slot(head, rd_off);
  assign sh_dst     = slot(head, off);
  assign sh_src     = slot(head, off + CW'(1));
  assign back_addr  = slot(head, count);
  assign front_addr = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) value <= in_value;
    if (cmd.rd) rd_data <= mem[rd_addr];
    if (cmd.shift) mem[sh_dst] <= mem[sh_src];
    else if (cmd.wr_front) mem[front_addr] <= value;
    else if (cmd.wr_back) mem[back_addr] <= value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      off   <= '0;
    end else begin
      if (cmd.load) off <= '0;
      else if (cmd.step) off <= off + CW'(1);
      if (cmd.wr_front) begin
        head  <= front_addr;
        count <= count + CW'(1);
      end else if (cmd.wr_back) begin
        count <= count + CW'(1);
      end else if (cmd.pop_front) begin
        head  <= slot(head, CW'(1));
        count <= count - CW'(1);
      end else if (cmd.pop_back || cmd.dec) begin
        count <= count - CW'(1);
      end
    end
  end

  assign sts.empty   = (count == '0);
  assign sts.full    = (count == CW'(DEPTH));
  assign sts.at_end  = (off == count);
  assign sts.at_last = (off + CW'(1) == count);
  assign sts.match   = (rd_data == value);

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_front || cmd.wr_back) |-> count != CW'(DEPTH)) else $error("push when full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back || cmd.dec) |-> count != '0) else $error("pop when empty");
`endif
endmodule

// ===== design/uvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// uvd_ctrl
// operation sequencer: scans, shifts and result beats
// ----------------------------------------------------------------------------
module uvd_ctrl
  import uvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  uvd_in_if.sink             in_ch,
  uvd_out_if.source          out_ch,
  output cmd_t               cmd,
  input  sts_t               sts,
  input  logic signed [31:0] rd_data,
  input  logic signed [31:0] value
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_SHIFT, S_LIST, S_LWAIT, S_OUT
  } state_t;

  state_t state;
  op_t    op;
  logic   hit;

  // push and pop updates happen on the beat leaving
  logic fin;
  assign fin = (state == S_OUT) && out_ch.ready && out_ch.status == ST_OK;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_ch.valid;
    // pop back reads the tail: offset zero reversed
    cmd.rev  = (op == OP_LIST_BWD) || (op == OP_POP_BACK);
    unique case (state)
      S_SCAN: if (!sts.at_end) begin
        cmd.rd = 1'b1;
      end
      S_CHECK: if (!sts.match) begin
        cmd.step = 1'b1;
      end
      S_SHIFT: if (!sts.at_last) begin
        cmd.shift = 1'b1;
        cmd.step  = 1'b1;
      end else begin
        cmd.dec = 1'b1;
      end
      S_LIST: cmd.rd = 1'b1;
      default: ;
    endcase
    if (fin) begin
      cmd.wr_front  = (op == OP_PUSH_FRONT);
      cmd.wr_back   = (op == OP_PUSH_BACK);
      cmd.pop_front = (op == OP_POP_FRONT);
      cmd.pop_back  = (op == OP_POP_BACK);
    end
    if ((state == S_OUT) && (op == OP_LIST_FWD || op == OP_LIST_BWD) && out_ch.ready)
      cmd.step = 1'b1;
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      op           <= OP_PUSH_FRONT;
      hit          <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          op  <= op_t'(in_ch.operation);
          hit <= 1'b0;
          out_ch.status <= ST_OK;
          out_ch.found  <= 1'b0;
          out_ch.item   <= '0;
          out_ch.last   <= 1'b0;
          if (op_t'(in_ch.operation) == OP_LIST_FWD ||
              op_t'(in_ch.operation) == OP_LIST_BWD) begin
            if (sts.empty) begin
              out_ch.status <= ST_EMPTY;
              out_ch.last   <= 1'b1;
              out_ch.valid  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_LIST;
            end
          end else if (sts.empty && op_t'(in_ch.operation) != OP_PUSH_FRONT &&
                       op_t'(in_ch.operation) != OP_PUSH_BACK) begin
            out_ch.status <= ST_EMPTY;
            out_ch.valid  <= 1'b1;
            state <= S_OUT;
          end else if (op_t'(in_ch.operation) == OP_POP_FRONT ||
                       op_t'(in_ch.operation) == OP_POP_BACK) begin
            state <= S_LIST;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.at_end) begin
            out_ch.valid <= 1'b1;
            state <= S_OUT;
            case (op)
              OP_PUSH_FRONT, OP_PUSH_BACK:
                out_ch.status <= hit ? ST_DUPLICATE : (sts.full ? ST_FULL : ST_OK);
              OP_SEARCH: out_ch.found <= hit;
              default: out_ch.status <= ST_NOT_FOUND;
            endcase
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.match) begin
            hit <= 1'b1;
            if (op == OP_REMOVE) begin
              out_ch.item <= value;
              state <= S_SHIFT;
            end else begin
              out_ch.valid <= 1'b1;
              state <= S_OUT;
              if (op == OP_SEARCH) out_ch.found <= 1'b1;
              else out_ch.status <= ST_DUPLICATE;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SHIFT: if (sts.at_last) begin
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_LIST: state <= S_LWAIT;
        S_LWAIT: begin
          out_ch.item  <= rd_data;
          out_ch.valid <= 1'b1;
          if (op == OP_LIST_FWD || op == OP_LIST_BWD) out_ch.last <= sts.at_last;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          if ((op == OP_LIST_FWD || op == OP_LIST_BWD) && !out_ch.last &&
              out_ch.status == ST_OK) begin
            state <= S_LIST;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while beat pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("valid outside output state");
  a_last_list: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last) |-> (op == OP_LIST_FWD || op == OP_LIST_BWD))
    else $error("last on non-list");
`endif
endmodule

// ===== tb/sv/uvd_checker.sv =====
// ----------------------------------------------------------------------------
// uvd_checker
// watches the operation and result channels of the unique value deque, keeps
// its own copy of the list, predicts every result beat and compares fields
// ----------------------------------------------------------------------------
module uvd_checker
  import uvd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  uvd_in_if     in_ch,
  uvd_out_if    out_ch,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] item;
    logic               last;
  } result_t;

  logic signed [31:0] list_q[$];
  result_t            result_q[$];

  function automatic int locate(logic signed [31:0] v);
    foreach (list_q[i]) if (list_q[i] == v) return i;
    return -1;
  endfunction

  function automatic result_t mk(status_t s, logic f, logic signed [31:0] it, logic l);
    result_t r;
    r.status = s;
    r.found  = f;
    r.item   = it;
    r.last   = l;
    return r;
  endfunction

  task automatic predict_op(op_t op, logic signed [31:0] v);
    int pos;
    pos = locate(v);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (pos >= 0) result_q.push_back(mk(ST_DUPLICATE, 0, 0, 0));
        else if (list_q.size() >= DEPTH) result_q.push_back(mk(ST_FULL, 0, 0, 0));
        else begin
          if (op == OP_PUSH_FRONT) list_q.push_front(v);
          else list_q.push_back(v);
          result_q.push_back(mk(ST_OK, 0, 0, 0));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_q.size() == 0) result_q.push_back(mk(ST_EMPTY, 0, 0, 0));
        else if (op == OP_POP_FRONT) result_q.push_back(mk(ST_OK, 0, list_q.pop_front(), 0));
        else result_q.push_back(mk(ST_OK, 0, list_q.pop_back(), 0));
      end
      OP_REMOVE: begin
        if (list_q.size() == 0) result_q.push_back(mk(ST_EMPTY, 0, 0, 0));
        else if (pos < 0) result_q.push_back(mk(ST_NOT_FOUND, 0, 0, 0));
        else begin
          list_q.delete(pos);
          result_q.push_back(mk(ST_OK, 0, v, 0));
        end
      end
      OP_SEARCH: begin
        if (list_q.size() == 0) result_q.push_back(mk(ST_EMPTY, 0, 0, 0));
        else result_q.push_back(mk(ST_OK, pos >= 0, 0, 0));
      end
      default: begin
        if (list_q.size() == 0) result_q.push_back(mk(ST_EMPTY, 0, 0, 1));
        else begin
          for (int i = 0; i < list_q.size(); i++) begin
            int k;
            k = (op == OP_LIST_FWD) ? i : list_q.size() - 1 - i;
            result_q.push_back(mk(ST_OK, 0, list_q[k], i == list_q.size() - 1));
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t got, want;
    int      n_err;
    if (rst) begin
      list_q.delete();
      result_q.delete();
      errors <= 0;
    end else begin
      n_err = 0;
      if (out_ch.valid && out_ch.ready) begin
        got = mk(status_t'(out_ch.status), out_ch.found, out_ch.item, out_ch.last);
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          n_err++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            n_err++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            n_err++;
          end
          if (got.item !== want.item) begin
            $display("%0t: item expected %0d actual %0d", $time, want.item, got.item);
            n_err++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            n_err++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_op(op_t'(in_ch.operation), in_ch.value);
      errors <= errors + n_err;
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/sv/unique_value_deque_core_tb.sv =====
// ----------------------------------------------------------------------------
// unique_value_deque_core_tb
// drives directed and random operation beats with random gaps and stalls,
// including a long result stall while operation beats are offered; checker gives verdict
// ----------------------------------------------------------------------------
module unique_value_deque_core_tb;
  import uvd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   ready_wait = 0;
  bit   hold_off = 0;
  bit   inputs_done = 0;
  logic signed [31:0] pool[8];

  uvd_in_if  in_ch();
  uvd_out_if out_ch();

  unique_value_deque_core i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  uvd_checker i_checker (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                         .errors(errors), .pending(pending));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.operation = OP_SEARCH;
    in_ch.value = 0;
    out_ch.ready = 0;
  end

  task automatic send_op(op_t op, logic signed [31:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // result side
  always @(posedge clk) begin
    int w;
    if (!rst) begin
      if (hold_off) out_ch.ready <= 0;
      else if (out_ch.valid && out_ch.ready) begin
        w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        ready_wait <= w;
        out_ch.ready <= (w == 0);
      end else if (ready_wait > 0) begin
        ready_wait <= ready_wait - 1;
        out_ch.ready <= (ready_wait == 1);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 0;
    pool[1] = -1;
    // directed
    send_op(OP_POP_FRONT, 0);
    send_op(OP_POP_BACK, 0);
    send_op(OP_REMOVE, 5);
    send_op(OP_SEARCH, 5);
    send_op(OP_LIST_FWD, 0);
    send_op(OP_LIST_BWD, 0);
    send_op(OP_PUSH_FRONT, 32'sh8000_0000);
    send_op(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_op(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_op(OP_SEARCH, 32'sh7fff_ffff);
    send_op(OP_SEARCH, 7);
    send_op(OP_REMOVE, 7);
    for (int i = 0; i < 15; i++) send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, i * 3 - 20);
    send_op(OP_PUSH_BACK, 99);
    send_op(OP_PUSH_FRONT, -20);
    send_op(OP_LIST_FWD, 0);
    send_op(OP_LIST_BWD, 0);
    send_op(OP_REMOVE, -17);
    send_op(OP_POP_FRONT, 0);
    send_op(OP_POP_BACK, 0);
    // long result stall while beats keep coming
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_op(OP_LIST_FWD, 0);
    join
    // random
    for (int n = 0; n < 370; n++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) send_op(op_t'($urandom_range(0, 1)), pick_value());
      else if (r < 55) send_op(op_t'($urandom_range(2, 3)), pick_value());
      else if (r < 75) send_op(OP_REMOVE, pick_value());
      else if (r < 90) send_op(OP_SEARCH, pick_value());
      else send_op(op_t'($urandom_range(6, 7)), $urandom);
      if (n % 60 == 59) foreach (pool[i]) pool[i] = $urandom;
    end
    in_ch.valid <= 0;
    inputs_done = 1;
  end

  initial begin
    @(posedge clk);
    while (!(inputs_done && pending == 0)) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
